FILE: hw/rtl/gcr62_pkg.sv
`timescale 1ns / 1ps

package gcr62_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_PULL  = 2'd2;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_LOADED = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME   = 2'd2;

  localparam logic [1:0] CFG_VOLUME     = 2'd0;
  localparam logic [1:0] CFG_ADDR_GAP   = 2'd1;
  localparam logic [1:0] CFG_SECTOR_GAP = 2'd2;

  localparam logic [7:0] VOLUME_RESET     = 8'd254;
  localparam logic [5:0] ADDR_GAP_RESET   = 6'd6;
  localparam logic [5:0] SECTOR_GAP_RESET = 6'd27;

  localparam int SectorBytes = 256;
  localparam int AuxSlots    = 86;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [8:0] ADDR_PRO_END = 9'd3;
  localparam logic [8:0] ADDR_FIELD_END = 9'd11;
  localparam logic [8:0] ADDR_EPI_END = 9'd14;
  localparam logic [8:0] MARK_LEN = 9'd3;
  localparam logic [8:0] DATA_NIBBLES = 9'd343;
  localparam logic [8:0] AUX_LAST = 9'd85;
  localparam logic [8:0] AUX_COUNT = 9'd86;
  localparam logic [8:0] CSUM_INDEX = 9'd342;
  localparam logic [7:0] PAIR1_BASE = 8'd86;
  localparam logic [7:0] PAIR2_BASE = 8'd172;
  localparam logic [6:0] PAIR2_SLOTS = 7'd84;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] track_num;
    logic [7:0] sector_num;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] nibble;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_LOAD,
    KIND_PULL,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] track_num;
    logic [7:0] sector_num;
    logic [7:0] data_byte;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_req_t;

  typedef struct packed {
    logic [7:0] volume;
    logic [5:0] addr_gap;
    logic [5:0] sector_gap;
  } cfg_t;

  function automatic logic [7:0] gcr_encode(input logic [5:0] v);
    logic [7:0] r;
    case (v)
      6'd0:  r = 8'h96;  6'd1:  r = 8'h97;  6'd2:  r = 8'h9A;  6'd3:  r = 8'h9B;
      6'd4:  r = 8'h9D;  6'd5:  r = 8'h9E;  6'd6:  r = 8'h9F;  6'd7:  r = 8'hA6;
      6'd8:  r = 8'hA7;  6'd9:  r = 8'hAB;  6'd10: r = 8'hAC;  6'd11: r = 8'hAD;
      6'd12: r = 8'hAE;  6'd13: r = 8'hAF;  6'd14: r = 8'hB2;  6'd15: r = 8'hB3;
      6'd16: r = 8'hB4;  6'd17: r = 8'hB5;  6'd18: r = 8'hB6;  6'd19: r = 8'hB7;
      6'd20: r = 8'hB9;  6'd21: r = 8'hBA;  6'd22: r = 8'hBB;  6'd23: r = 8'hBC;
      6'd24: r = 8'hBD;  6'd25: r = 8'hBE;  6'd26: r = 8'hBF;  6'd27: r = 8'hCB;
      6'd28: r = 8'hCD;  6'd29: r = 8'hCE;  6'd30: r = 8'hCF;  6'd31: r = 8'hD3;
      6'd32: r = 8'hD6;  6'd33: r = 8'hD7;  6'd34: r = 8'hD9;  6'd35: r = 8'hDA;
      6'd36: r = 8'hDB;  6'd37: r = 8'hDC;  6'd38: r = 8'hDD;  6'd39: r = 8'hDE;
      6'd40: r = 8'hDF;  6'd41: r = 8'hE5;  6'd42: r = 8'hE6;  6'd43: r = 8'hE7;
      6'd44: r = 8'hE9;  6'd45: r = 8'hEA;  6'd46: r = 8'hEB;  6'd47: r = 8'hEC;
      6'd48: r = 8'hED;  6'd49: r = 8'hEE;  6'd50: r = 8'hEF;  6'd51: r = 8'hF2;
      6'd52: r = 8'hF3;  6'd53: r = 8'hF4;  6'd54: r = 8'hF5;  6'd55: r = 8'hF6;
      6'd56: r = 8'hF7;  6'd57: r = 8'hF9;  6'd58: r = 8'hFA;  6'd59: r = 8'hFB;
      6'd60: r = 8'hFC;  6'd61: r = 8'hFD;  6'd62: r = 8'hFE;  default: r = 8'hFF;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] addr_prologue(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'hD5;
      2'd1:    r = 8'hAA;
      default: r = 8'h96;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] data_prologue(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'hD5;
      2'd1:    r = 8'hAA;
      default: r = 8'hAD;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] epilogue(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'hDE;
      2'd1:    r = 8'hAA;
      default: r = 8'hEB;
    endcase
    return r;
  endfunction

  // Address field bytes are sent in 4-and-4 form, odd bits first.
  function automatic logic [7:0] addr_field_byte(input logic [2:0] idx, input logic [7:0] vol,
                                                 input logic [7:0] trk, input logic [7:0] sec);
    logic [7:0] v;
    case (idx[2:1])
      2'd0:    v = vol;
      2'd1:    v = trk;
      2'd2:    v = sec;
      default: v = vol ^ trk ^ sec;
    endcase
    if (!idx[0]) begin
      v = {1'b0, v[7:1]};
    end
    return v | 8'hAA;
  endfunction

endpackage

FILE: hw/rtl/gcr62_ram.sv
`timescale 1ns / 1ps

module gcr62_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/gcr62_front.sv
`timescale 1ns / 1ps

module gcr62_front #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gcr62_pkg::in_item_t in_data,
  output gcr62_pkg::q_req_t  req,
  input  logic               req_ready
);

  import gcr62_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  q_item_t           mem_r [DEPTH];
  q_item_t           item_w;
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              push, pop;

  always_comb begin
    item_w.track_num  = in_data.track_num;
    item_w.sector_num = in_data.sector_num;
    item_w.data_byte  = in_data.data_byte;
    case (in_data.opcode)
      OP_START: item_w.kind = KIND_START;
      OP_LOAD:  item_w.kind = KIND_LOAD;
      OP_PULL:  item_w.kind = KIND_PULL;
      default:  item_w.kind = KIND_NOP;
    endcase
  end

  assign in_ready  = (count_r != CntW'(DEPTH));
  assign push      = in_valid && in_ready;
  assign req.valid = (count_r != '0);
  assign req.item  = mem_r[rd_ptr_r];
  assign pop       = req.valid && req_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_w;
    end
  end

endmodule

FILE: hw/rtl/gcr62_back.sv
`timescale 1ns / 1ps

module gcr62_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gcr62_pkg::q_req_t   req,
  output logic                req_ready,
  input  gcr62_pkg::cfg_t     cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output gcr62_pkg::out_item_t out_data
);

  import gcr62_pkg::*;

  typedef enum logic [1:0] {
    SEG_CONST,
    SEG_AUX,
    SEG_PRIM,
    SEG_CSUM
  } seg_t;

  // Frame state.
  logic [8:0] pos_r, pos_nxt;
  logic [8:0] load_r, load_nxt;
  logic       active_r, active_nxt;
  logic [7:0] track_r, track_nxt;
  logic [7:0] sector_r, sector_nxt;
  logic [5:0] chain_r, chain_nxt;

  // Second stage.
  logic       b_valid_r, b_valid_nxt;
  logic       b_clear_r, b_clear_nxt;
  seg_t       b_seg_r, b_seg_nxt;
  logic [7:0] b_const_r, b_const_nxt;
  logic       b_last_r, b_last_nxt;
  logic [1:0] b_status_r, b_status_nxt;
  logic       b_hi_zero_r, b_hi_zero_nxt;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic       a_fire, b_adv;

  // Memory ports.
  logic       prim_we, aux0_we, aux1_we, aux2_we, ram_re;
  logic [7:0] prim_waddr, prim_raddr;
  logic [6:0] aux_waddr, aux_raddr;
  logic [5:0] prim_wdata, prim_rdata;
  logic [1:0] aux_wdata, aux0_rdata, aux1_rdata, aux2_rdata;

  // Frame layout from the current register values.
  logic [8:0] gap1_end, dpro_end, data_end, epi_end;
  logic [9:0] frame_end, pos_inc;
  logic [8:0] off_addr, off_epi1, off_dpro, off_data, off_epi2;
  logic [7:0] load_idx;

  assign gap1_end  = ADDR_EPI_END + {3'b000, cfg.addr_gap};
  assign dpro_end  = gap1_end + MARK_LEN;
  assign data_end  = dpro_end + DATA_NIBBLES;
  assign epi_end   = data_end + MARK_LEN;
  assign frame_end = {1'b0, epi_end} + {4'b0000, cfg.sector_gap};
  assign pos_inc   = {1'b0, pos_r} + 10'd1;
  assign off_addr  = pos_r - ADDR_PRO_END;
  assign off_epi1  = pos_r - ADDR_FIELD_END;
  assign off_dpro  = pos_r - gap1_end;
  assign off_data  = pos_r - dpro_end;
  assign off_epi2  = pos_r - data_end;
  assign load_idx  = load_r[7:0];

  assign b_adv     = b_valid_r && (b_clear_r || !out_valid_r || out_ready);
  assign a_fire    = req.valid && (!b_valid_r || b_adv);
  assign req_ready = !b_valid_r || b_adv;
  assign ram_re    = a_fire;

  always_comb begin
    pos_nxt       = pos_r;
    load_nxt      = load_r;
    active_nxt    = active_r;
    track_nxt     = track_r;
    sector_nxt    = sector_r;
    b_valid_nxt   = b_valid_r;
    b_clear_nxt   = b_clear_r;
    b_seg_nxt     = b_seg_r;
    b_const_nxt   = b_const_r;
    b_last_nxt    = b_last_r;
    b_status_nxt  = b_status_r;
    b_hi_zero_nxt = b_hi_zero_r;
    prim_we       = 1'b0;
    aux0_we       = 1'b0;
    aux1_we       = 1'b0;
    aux2_we       = 1'b0;
    prim_waddr    = load_idx;
    prim_wdata    = req.item.data_byte[7:2];
    aux_wdata     = {req.item.data_byte[0], req.item.data_byte[1]};
    aux_waddr     = 7'(load_idx);
    prim_raddr    = 8'(off_data - AUX_COUNT);
    aux_raddr     = 7'(AUX_LAST - off_data);
    if (b_adv) begin
      b_valid_nxt = 1'b0;
    end
    if (a_fire) begin
      case (req.item.kind)
        KIND_START: begin
          track_nxt   = req.item.track_num;
          sector_nxt  = req.item.sector_num;
          load_nxt    = '0;
          pos_nxt     = '0;
          active_nxt  = 1'b1;
          b_valid_nxt = 1'b1;
          b_clear_nxt = 1'b1;
        end
        KIND_LOAD: begin
          if (!load_r[8]) begin
            prim_we  = 1'b1;
            load_nxt = load_r + 9'd1;
            if (load_idx < PAIR1_BASE) begin
              aux0_we = 1'b1;
            end else if (load_idx < PAIR2_BASE) begin
              aux1_we   = 1'b1;
              aux_waddr = 7'(load_idx - PAIR1_BASE);
            end else begin
              aux2_we   = 1'b1;
              aux_waddr = 7'(load_idx - PAIR2_BASE);
            end
          end
        end
        KIND_PULL: begin
          b_valid_nxt   = 1'b1;
          b_clear_nxt   = 1'b0;
          b_seg_nxt     = SEG_CONST;
          b_const_nxt   = 8'h00;
          b_last_nxt    = 1'b0;
          b_status_nxt  = STATUS_OK;
          b_hi_zero_nxt = (aux_raddr >= PAIR2_SLOTS);
          if (!active_r) begin
            b_status_nxt = STATUS_NO_FRAME;
          end else if (pos_r >= dpro_end && pos_r < data_end && !load_r[8]) begin
            b_status_nxt = STATUS_NOT_LOADED;
          end else begin
            b_last_nxt = (pos_inc >= frame_end);
            pos_nxt    = pos_inc[8:0];
            if (pos_inc >= frame_end) begin
              active_nxt = 1'b0;
            end
            if (pos_r < ADDR_PRO_END) begin
              b_const_nxt = addr_prologue(pos_r[1:0]);
            end else if (pos_r < ADDR_FIELD_END) begin
              b_const_nxt = addr_field_byte(off_addr[2:0], cfg.volume, track_r, sector_r);
            end else if (pos_r < ADDR_EPI_END) begin
              b_const_nxt = epilogue(off_epi1[1:0]);
            end else if (pos_r < gap1_end) begin
              b_const_nxt = SYNC_BYTE;
            end else if (pos_r < dpro_end) begin
              b_const_nxt = data_prologue(off_dpro[1:0]);
            end else if (pos_r < data_end) begin
              if (off_data < AUX_COUNT) begin
                b_seg_nxt = SEG_AUX;
              end else if (off_data < CSUM_INDEX) begin
                b_seg_nxt = SEG_PRIM;
              end else begin
                b_seg_nxt = SEG_CSUM;
              end
            end else if (pos_r < epi_end) begin
              b_const_nxt = epilogue(off_epi2[1:0]);
            end else begin
              b_const_nxt = SYNC_BYTE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  logic [5:0] aux_value, data_value;

  // The last two auxiliary slots get no third bit pair.
  assign aux_value  = {b_hi_zero_r ? 2'b00 : aux2_rdata, aux1_rdata, aux0_rdata};
  assign data_value = (b_seg_r == SEG_AUX) ? aux_value : prim_rdata;

  always_comb begin
    chain_nxt     = chain_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (b_adv) begin
      if (b_clear_r) begin
        chain_nxt = '0;
      end else begin
        out_valid_nxt       = 1'b1;
        out_item_nxt.last   = b_last_r;
        out_item_nxt.status = b_status_r;
        case (b_seg_r)
          SEG_AUX, SEG_PRIM: begin
            out_item_nxt.nibble = gcr_encode(data_value ^ chain_r);
            chain_nxt           = data_value;
          end
          SEG_CSUM: out_item_nxt.nibble = gcr_encode(chain_r);
          default:  out_item_nxt.nibble = b_const_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      load_r      <= '0;
      active_r    <= 1'b0;
      track_r     <= '0;
      sector_r    <= '0;
      chain_r     <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      load_r      <= load_nxt;
      active_r    <= active_nxt;
      track_r     <= track_nxt;
      sector_r    <= sector_nxt;
      chain_r     <= chain_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_clear_r   <= b_clear_nxt;
    b_seg_r     <= b_seg_nxt;
    b_const_r   <= b_const_nxt;
    b_last_r    <= b_last_nxt;
    b_status_r  <= b_status_nxt;
    b_hi_zero_r <= b_hi_zero_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  gcr62_ram #(.WIDTH(6), .DEPTH(SectorBytes)) u_prim_ram (
    .clk   (clk),
    .we    (prim_we),
    .waddr (prim_waddr),
    .wdata (prim_wdata),
    .re    (ram_re),
    .raddr (prim_raddr),
    .rdata (prim_rdata)
  );

  gcr62_ram #(.WIDTH(2), .DEPTH(AuxSlots)) u_aux0_ram (
    .clk   (clk),
    .we    (aux0_we),
    .waddr (aux_waddr),
    .wdata (aux_wdata),
    .re    (ram_re),
    .raddr (aux_raddr),
    .rdata (aux0_rdata)
  );

  gcr62_ram #(.WIDTH(2), .DEPTH(AuxSlots)) u_aux1_ram (
    .clk   (clk),
    .we    (aux1_we),
    .waddr (aux_waddr),
    .wdata (aux_wdata),
    .re    (ram_re),
    .raddr (aux_raddr),
    .rdata (aux1_rdata)
  );

  gcr62_ram #(.WIDTH(2), .DEPTH(AuxSlots)) u_aux2_ram (
    .clk   (clk),
    .we    (aux2_we),
    .waddr (aux_waddr),
    .wdata (aux_wdata),
    .re    (ram_re),
    .raddr (aux_raddr),
    .rdata (aux2_rdata)
  );

endmodule

FILE: hw/rtl/gcr_six_and_two_sector_encoder.sv
`timescale 1ns / 1ps
// An accepted pull passes the issue stage register, then the output register.
// Throughput: one transaction per cycle while out_ready drains results; the
// input queue, issue stage and registered memory read each take one per cycle.
// Reset: synchronous, active low; clears the queue, the pipeline and the frame
// state at once, with no clearing pass over the memories.

module gcr_six_and_two_sector_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gcr62_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gcr62_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata
);

  import gcr62_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  q_req_t req;
  logic   req_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VOLUME:     cfg_nxt.volume     = cfg_wdata;
        CFG_ADDR_GAP:   cfg_nxt.addr_gap   = cfg_wdata[5:0];
        CFG_SECTOR_GAP: cfg_nxt.sector_gap = cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volume     <= VOLUME_RESET;
      cfg_r.addr_gap   <= ADDR_GAP_RESET;
      cfg_r.sector_gap <= SECTOR_GAP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gcr62_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .req       (req),
    .req_ready (req_ready)
  );

  gcr62_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_ready (req_ready),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/gcr62_checker.sv
`timescale 1ns / 1ps

module gcr62_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input gcr62_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input gcr62_pkg::out_item_t out_data
);

  import gcr62_pkg::*;

  // An input transaction that is not taken stays offered with the same payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // A result transaction that is not taken holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A refused pull carries no disk byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_OK |-> out_data.nibble == 8'h00 && !out_data.last)
    else $error("refused pull carries data");

  // Only a good nibble may end a frame, and the last byte of a frame is a sync or mark byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |->
      out_data.status == STATUS_OK && (out_data.nibble == 8'hFF || out_data.nibble == 8'hEB))
    else $error("bad frame end");

  // No result may come out of a pipeline that has just been reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind gcr_six_and_two_sector_encoder gcr62_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: verif/gcr62_frame_sb_pkg.sv
`timescale 1ns / 1ps

package gcr62_frame_sb_pkg;
  import gcr62_pkg::*;

  class sector_frame_scoreboard;
    logic [7:0] code_of [64];
    logic [7:0] addr_mark [3];
    logic [7:0] data_mark [3];
    logic [7:0] end_mark [3];

    logic [7:0] volume;
    logic [5:0] addr_gap;
    logic [5:0] sector_gap;

    logic [5:0] primary [256];
    logic [5:0] aux [86];
    int unsigned loaded;
    int unsigned position;
    logic [5:0] chain;
    logic [7:0] track;
    logic [7:0] sector;
    bit active;

    out_item_t expected_q[$];
    int errors;
    int checked;
    int status_seen [3];
    int frames_closed;

    function new();
      code_of = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
      };
      addr_mark = '{8'hD5, 8'hAA, 8'h96};
      data_mark = '{8'hD5, 8'hAA, 8'hAD};
      end_mark = '{8'hDE, 8'hAA, 8'hEB};
      volume = VOLUME_RESET;
      addr_gap = ADDR_GAP_RESET;
      sector_gap = SECTOR_GAP_RESET;
      foreach (primary[i]) primary[i] = '0;
      foreach (aux[i]) aux[i] = '0;
      loaded = 0;
      position = 0;
      chain = '0;
      track = '0;
      sector = '0;
      active = 1'b0;
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      frames_closed = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] value);
      case (idx)
        CFG_VOLUME: volume = value;
        CFG_ADDR_GAP: addr_gap = value[5:0];
        CFG_SECTOR_GAP: sector_gap = value[5:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [7:0] address_nibble(int unsigned idx);
      logic [7:0] v;
      case (idx / 2)
        0: v = volume;
        1: v = track;
        2: v = sector;
        default: v = volume ^ track ^ sector;
      endcase
      if (idx % 2 == 0) v = v >> 1;
      return v | 8'hAA;
    endfunction

    function out_item_t predict_pull();
      out_item_t r;
      int unsigned gap_end;
      int unsigned dpro_end;
      int unsigned data_end;
      int unsigned epi_end;
      int unsigned frame_end;
      int unsigned d;
      logic [5:0] v;
      r = '0;
      if (!active) begin
        r.status = STATUS_NO_FRAME;
        return r;
      end
      gap_end = 14 + addr_gap;
      dpro_end = gap_end + 3;
      data_end = dpro_end + 343;
      epi_end = data_end + 3;
      frame_end = epi_end + sector_gap;
      if (position < 3) begin
        r.nibble = addr_mark[position];
      end else if (position < 11) begin
        r.nibble = address_nibble(position - 3);
      end else if (position < 14) begin
        r.nibble = end_mark[position - 11];
      end else if (position < gap_end) begin
        r.nibble = SYNC_BYTE;
      end else if (position < dpro_end) begin
        r.nibble = data_mark[position - gap_end];
      end else if (position < data_end) begin
        if (loaded < SectorBytes) begin
          r.status = STATUS_NOT_LOADED;
          return r;
        end
        d = position - dpro_end;
        if (d < AuxSlots) begin
          v = aux[85 - d];
          r.nibble = code_of[v ^ chain];
          chain = v;
        end else if (d < 342) begin
          v = primary[d - 86];
          r.nibble = code_of[v ^ chain];
          chain = v;
        end else begin
          r.nibble = code_of[chain];
        end
      end else if (position < epi_end) begin
        r.nibble = end_mark[position - data_end];
      end else begin
        r.nibble = SYNC_BYTE;
      end
      r.last = (position + 1 >= frame_end);
      if (r.last) begin
        active = 1'b0;
        frames_closed++;
      end
      position = (position + 1) % 512;
      r.status = STATUS_OK;
      return r;
    endfunction

    function void note_input(in_item_t it);
      int unsigned slot;
      int unsigned pair;
      logic [5:0] bits;
      case (it.opcode)
        OP_START: begin
          track = it.track_num;
          sector = it.sector_num;
          foreach (aux[i]) aux[i] = '0;
          loaded = 0;
          position = 0;
          chain = '0;
          active = 1'b1;
        end
        OP_LOAD: begin
          if (loaded < SectorBytes) begin
            slot = loaded % AuxSlots;
            pair = loaded / AuxSlots;
            bits = {4'b0000, it.data_byte[0], it.data_byte[1]};
            primary[loaded] = it.data_byte[7:2];
            aux[slot] = aux[slot] | (bits << (2 * pair));
            loaded++;
          end
        end
        OP_PULL: expected_q.push_back(predict_pull());
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= 40) begin
        $display("tb_top: mismatch in %s: got 0x%0h, expected 0x%0h (result %0d)",
                 what, got, want, checked);
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", got, 0);
        return;
      end
      want = expected_q.pop_front();
      status_seen[want.status]++;
      if (got.nibble !== want.nibble) report_mismatch("nibble", got.nibble, want.nibble);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    endtask
  endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gcr62_pkg::*;
  import gcr62_frame_sb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RandomItems = 1250;
  localparam int IdleLimit = 4000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles = 400;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  sector_frame_scoreboard sb;
  int items_sent;
  int burst_left;
  bit bursty;
  int hold_requests;
  int settings_used;

  gcr_six_and_two_sector_encoder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_item_t make_item(logic [1:0] op);
    in_item_t it;
    it.opcode = op;
    it.track_num = 8'($urandom);
    it.sector_num = 8'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_op(logic [1:0] op);
    send_item(make_item(op));
  endtask

  task automatic send_start(logic [7:0] trk, logic [7:0] sec);
    in_item_t it;
    it = make_item(OP_START);
    it.track_num = trk;
    it.sector_num = sec;
    send_item(it);
  endtask

  task automatic send_load(logic [7:0] value);
    in_item_t it;
    it = make_item(OP_LOAD);
    it.data_byte = value;
    send_item(it);
  endtask

  // Waits until every pull has been answered and the pipeline has emptied.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_config(logic [7:0] vol, logic [5:0] agap, logic [5:0] sgap);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_VOLUME;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_index <= CFG_ADDR_GAP;
    cfg_wdata <= {2'b00, agap};
    @(posedge clk);
    cfg_index <= CFG_SECTOR_GAP;
    cfg_wdata <= {2'b00, sgap};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_register(CFG_VOLUME, vol);
    sb.set_register(CFG_ADDR_GAP, {2'b00, agap});
    sb.set_register(CFG_SECTOR_GAP, {2'b00, sgap});
    settings_used++;
  endtask

  task automatic run_frame(bit midcfg, bit hold);
    int k;
    send_start(8'($urandom), 8'($urandom));
    while (sb.loaded < SectorBytes) begin
      if ($urandom_range(0, 4) == 0) send_op(OP_PULL);
      else send_op(OP_LOAD);
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) send_op(OP_LOAD);
    if (hold) hold_requests++;
    if (midcfg) begin
      k = $urandom_range(0, 400);
      while (sb.active && k > 0) begin
        send_op(OP_PULL);
        k--;
      end
      drain();
      write_config(8'($urandom), 6'($urandom_range(0, 20)),
                   6'($urandom_range(0, 1) * $urandom_range(0, 20)));
    end
    while (sb.active) begin
      k = $urandom_range(0, 49);
      if (k == 0) send_op(OP_UNUSED);
      else if (k == 1) send_op(OP_LOAD);
      else send_op(OP_PULL);
    end
    repeat ($urandom_range(0, 2)) send_op(OP_PULL);
  endtask

  task automatic run_partial_frame();
    int k;
    send_start(8'($urandom), 8'($urandom));
    k = $urandom_range(0, 255);
    while (k > 0) begin
      if ($urandom_range(0, 2) == 0) begin
        send_op(OP_PULL);
      end else begin
        send_op(OP_LOAD);
        k--;
      end
    end
    repeat ($urandom_range(1, 4)) send_op(OP_PULL);
  endtask

  task automatic run_noise();
    int k;
    repeat ($urandom_range(5, 40)) begin
      k = $urandom_range(0, 5);
      if (k == 0) send_op(OP_UNUSED);
      else if (k < 3) send_op(OP_LOAD);
      else send_op(OP_PULL);
    end
  endtask

  initial begin : stimulus
    int phase;
    int pick;
    int target;
    logic [5:0] agap;
    logic [5:0] sgap;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_VOLUME;
    cfg_wdata = '0;
    items_sent = 0;
    burst_left = 0;
    bursty = 1'b0;
    hold_requests = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_config(8'h00, 6'd0, 6'd0);
    send_op(OP_PULL);
    send_load(8'h00);
    send_load(8'hFF);
    send_op(OP_UNUSED);
    send_start(8'hFF, 8'h00);
    repeat (18) send_op(OP_PULL);
    send_start(8'h00, 8'hFF);

    target = items_sent + RandomItems;
    phase = 0;
    while (phase < 2 || items_sent < target) begin
      drain();
      bursty = ($urandom_range(0, 3) != 0);
      case (phase)
        0: begin
          write_config(8'hFF, 6'd63, 6'd63);
          run_frame(1'b0, 1'b1);
        end
        1: begin
          write_config(8'h00, 6'($urandom_range(0, 63)), 6'd0);
          run_frame(1'b1, 1'b0);
        end
        default: begin
          pick = $urandom_range(0, 4);
          agap = 6'($urandom_range(0, 10));
          sgap = 6'($urandom_range(0, 10));
          if (pick == 0) begin
            agap = 6'd0;
            sgap = 6'd63;
          end else if (pick == 1) begin
            agap = 6'd63;
            sgap = 6'd0;
          end
          write_config(8'($urandom), agap, sgap);
          pick = $urandom_range(0, 9);
          if (pick < 5) run_frame($urandom_range(0, 3) == 0, 1'b0);
          else if (pick == 5) run_frame(1'b1, 1'b0);
          else if (pick < 8) run_partial_frame();
          else run_noise();
        end
      endcase
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("tb_top: %0d transactions sent under %0d register settings, %0d frames closed",
             items_sent, settings_used, sb.frames_closed);
    $display("tb_top: %0d results checked: %0d ok, %0d early data pulls, %0d with no frame",
             sb.checked, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_NOT_LOADED],
             sb.status_seen[STATUS_NO_FRAME]);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_left;
    int holds_served;
    int tick;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    holds_served = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (holds_served < hold_requests) begin
        hold_left = HoldCycles;
        holds_served++;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 2) != 0);
          2: out_ready <= (tick % 5 != 0);
          default: out_ready <= ((tick / 7) % 2 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: no transaction for %0d cycles", IdleLimit);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
